// ===== rtl/core/fpc_pkg.sv =====
// Package for the framed packet checker: status codes, frame constants and
// the byte-wide CRC-16 update. No dependencies.
package fpc_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_START  = 3'd2;
  localparam logic [2:0] ST_BAD_END    = 3'd3;
  localparam logic [2:0] ST_LEN_ERR    = 3'd4;
  localparam logic [2:0] ST_CRC_ERR    = 3'd5;

  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] POS_MAX  = 16'hFFFF;

  localparam logic [7:0]  START_MARKER_RST = 8'hAA;
  localparam logic [7:0]  END_MARKER_RST   = 8'h55;
  localparam logic [15:0] MAX_PAYLOAD_RST  = 16'd256;

  // Smallest legal frame: start, command, sequence, length, CRC, end.
  localparam logic [16:0] MIN_FRAME = 17'd9;
  localparam logic [16:0] HDR_BYTES = 17'd6;

  localparam int OUT_DATA_W = 184;

  // CRC-16/CCITT-FALSE update over one byte, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/framed_packet_checker.sv =====
// Framed packet checker: parses start/command/sequence/length/payload/CRC/end
// frames one byte per transaction. Depends on fpc_pkg.
// Timing: a result is registered and appears on the output in the cycle after its input transaction.
// Throughput: one byte per cycle while the output register is free or being taken;
// the frame state and CRC update for a byte are done in one pass in front of it.
// Reset: rst_n is synchronous and active low; it restores the register defaults,
// clears the frame state and counters and empties the output register.
module framed_packet_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream. in_tdata: rx_byte[7:0]. in_tlast: frame_end.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           in_tlast,
  // Result stream. out_tuser: kind.
  // out_tdata: payload_byte[7:0], payload_index[23:8], command[31:24],
  // sequence_res[47:32], length[63:48], received_crc[79:64], status[82:80],
  // good_frames[114:83], error_frames[146:115], good_bytes[178:147], zero[183:179].
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fpc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tuser,
  // Configuration writes.
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata
);
  import fpc_pkg::*;

  logic [7:0]  start_marker_r, end_marker_r;
  logic [15:0] max_payload_r;

  logic [15:0] pos_r, crc_r, seq_r, len_r, held_crc_r;
  logic [7:0]  first_r, cmd_r;
  logic [31:0] good_r, err_r, bytes_r;

  logic [15:0] pos_nxt, crc_nxt, seq_nxt, len_nxt, held_crc_nxt;
  logic [7:0]  first_nxt, cmd_nxt;
  logic [31:0] good_nxt, err_nxt, bytes_nxt;

  logic                  out_valid_r, out_kind_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic        in_acc, sat, in_payload, emit, crc_feed, crc_cap, res_load;
  logic [16:0] idx17, pend, n;
  logic [2:0]  st;
  logic [7:0]  b;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  assign b     = in_tdata;
  assign idx17 = {1'b0, pos_r};
  assign pend  = {1'b0, len_r} + HDR_BYTES;
  assign sat   = (pos_r == POS_MAX);
  assign n     = idx17 + 17'd1;

  assign in_payload = !sat && (pos_r >= 16'd6) && (idx17 < pend);
  assign emit       = in_payload && (len_r <= max_payload_r);
  assign crc_feed   = !sat && (pos_r >= 16'd1) && ((pos_r <= 16'd5) || (idx17 < pend));
  assign crc_cap    = !sat && (pos_r >= 16'd6) && !(idx17 < pend) &&
                      ((idx17 == pend) || (idx17 == pend + 17'd1));
  assign res_load   = in_acc && (in_tlast || emit);

  // Frame field capture for this byte, before any end-of-frame clear.
  always_comb begin
    first_nxt    = first_r;
    cmd_nxt      = cmd_r;
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    held_crc_nxt = held_crc_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_feed ? crc16_byte(crc_r, b) : crc_r;
    if (!sat) begin
      pos_nxt = pos_r + 16'd1;
      if (pos_r == 16'd0) begin
        first_nxt = b;
      end else if (pos_r == 16'd1) begin
        cmd_nxt = b;
      end else if (pos_r <= 16'd3) begin
        seq_nxt = {seq_r[7:0], b};
      end else if (pos_r <= 16'd5) begin
        len_nxt = {len_r[7:0], b};
      end else if (crc_cap) begin
        held_crc_nxt = {held_crc_r[7:0], b};
      end
    end
  end

  // Status and counters for a frame that ends on this byte, and the result word for the byte.
  always_comb begin
    if (n < MIN_FRAME) begin
      st = ST_TOO_SHORT;
    end else if (first_nxt != start_marker_r) begin
      st = ST_BAD_START;
    end else if (b != end_marker_r) begin
      st = ST_BAD_END;
    end else if (sat || (n != MIN_FRAME + {1'b0, len_nxt})) begin
      st = ST_LEN_ERR;
    end else if (held_crc_nxt != crc_nxt) begin
      st = ST_CRC_ERR;
    end else begin
      st = ST_OK;
    end

    good_nxt  = good_r;
    err_nxt   = err_r;
    bytes_nxt = bytes_r;
    if (in_tlast) begin
      if ((st == ST_LEN_ERR) || (st == ST_CRC_ERR)) begin
        err_nxt = err_r + 32'd1;
      end
      if (st == ST_OK) begin
        good_nxt  = good_r + 32'd1;
        bytes_nxt = bytes_r + {15'd0, n};
      end
    end

    out_data_nxt = '0;
    if (in_tlast) begin
      if ((st == ST_OK) || (st == ST_LEN_ERR) || (st == ST_CRC_ERR)) begin
        out_data_nxt[31:24] = cmd_nxt;
        out_data_nxt[47:32] = seq_nxt;
        out_data_nxt[63:48] = len_nxt;
      end
      if ((st == ST_OK) || (st == ST_CRC_ERR)) begin
        out_data_nxt[79:64] = held_crc_nxt;
      end
      out_data_nxt[82:80]   = st;
      out_data_nxt[114:83]  = good_nxt;
      out_data_nxt[146:115] = err_nxt;
      out_data_nxt[178:147] = bytes_nxt;
    end else begin
      out_data_nxt[7:0]  = b;
      out_data_nxt[23:8] = pos_r - 16'd6;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      end_marker_r   <= END_MARKER_RST;
      max_payload_r  <= MAX_PAYLOAD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_MARKER: start_marker_r <= cfg_wdata[7:0];
        REG_END_MARKER:   end_marker_r   <= cfg_wdata[7:0];
        REG_MAX_PAYLOAD:  max_payload_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= CRC_INIT;
      first_r    <= '0;
      cmd_r      <= '0;
      seq_r      <= '0;
      len_r      <= '0;
      held_crc_r <= '0;
      good_r     <= '0;
      err_r      <= '0;
      bytes_r    <= '0;
    end else if (in_acc) begin
      good_r  <= good_nxt;
      err_r   <= err_nxt;
      bytes_r <= bytes_nxt;
      if (in_tlast) begin
        pos_r      <= '0;
        crc_r      <= CRC_INIT;
        first_r    <= '0;
        cmd_r      <= '0;
        seq_r      <= '0;
        len_r      <= '0;
        held_crc_r <= '0;
      end else begin
        pos_r      <= pos_nxt;
        crc_r      <= crc_nxt;
        first_r    <= first_nxt;
        cmd_r      <= cmd_nxt;
        seq_r      <= seq_nxt;
        len_r      <= len_nxt;
        held_crc_r <= held_crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind_r <= in_tlast;
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> (pos_r == 16'd0) && (crc_r == CRC_INIT) && (len_r == 16'd0))
    else $error("frame state not cleared after the last byte");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tlast && !sat |=> pos_r == $past(pos_r) + 16'd1)
    else $error("position did not advance on an accepted byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r)
    else $error("input stalled with an empty output register");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_kind_r |-> out_data_r[OUT_DATA_W-1:24] == '0)
    else $error("payload result carries summary fields");

  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast && (st == ST_OK) |=> good_r == $past(good_r) + 32'd1)
    else $error("good frame counter did not advance on a good frame");
`endif

endmodule

// ===== sim/frame_result_checker.sv =====
// Checker for the framed packet checker: watches the byte, result and register
// ports, predicts every result and compares it field by field.
// Depends on fpc_pkg for the status codes, register indexes and frame constants.
module frame_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [7:0]                     in_tdata,
  input  logic                           in_tlast,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [fpc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output int                             mismatches,
  output int                             pending,
  output int                             results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [15:0] length;
    logic [15:0] rx_crc;
    logic [2:0]  status;
    logic [31:0] good_frames;
    logic [31:0] error_frames;
    logic [31:0] good_bytes;
  } frame_result_t;

  frame_result_t pending_results[$];

  logic [7:0]  start_mk, end_mk;
  logic [15:0] max_pl;
  logic [15:0] pos, crc_acc, seq_h, len_h, crc_h;
  logic [7:0]  first_b, cmd_h;
  logic [31:0] good_cnt, err_cnt, byte_cnt;
  int          fail_count;
  int          seen_count;

  // Bit-serial form of the CCITT update, one data bit folded in per step.
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    pos     = '0;
    crc_acc = CRC_INIT;
    first_b = '0;
    cmd_h   = '0;
    seq_h   = '0;
    len_h   = '0;
    crc_h   = '0;
  endfunction

  // Advances the frame state by one byte and queues the result it causes.
  function automatic void parse_byte(input logic [7:0] b, input logic last);
    logic [16:0]   idx, pend, n;
    logic          sat, emit;
    logic [2:0]    st;
    frame_result_t r;
    idx  = {1'b0, pos};
    sat  = (pos == POS_MAX);
    pend = HDR_BYTES + {1'b0, len_h};
    emit = 1'b0;
    r    = '0;
    if (!sat) begin
      if (idx == 0) first_b = b;
      else if (idx == 1) cmd_h = b;
      else if (idx <= 3) seq_h = {seq_h[7:0], b};
      else if (idx <= 5) len_h = {len_h[7:0], b};
      else if (idx < pend) emit = (len_h <= max_pl);
      else if (idx == pend || idx == pend + 1) crc_h = {crc_h[7:0], b};
      if (idx >= 1 && (idx <= 5 || idx < pend)) crc_acc = crc_ccitt_step(crc_acc, b);
      pos = pos + 16'd1;
    end
    if (last) begin
      n = idx + 17'd1;
      if (n < MIN_FRAME) st = ST_TOO_SHORT;
      else if (first_b != start_mk) st = ST_BAD_START;
      else if (b != end_mk) st = ST_BAD_END;
      else if (sat || n != MIN_FRAME + {1'b0, len_h}) st = ST_LEN_ERR;
      else if (crc_h != crc_acc) st = ST_CRC_ERR;
      else st = ST_OK;
      if (st == ST_LEN_ERR || st == ST_CRC_ERR) err_cnt = err_cnt + 32'd1;
      if (st == ST_OK) begin
        good_cnt = good_cnt + 32'd1;
        byte_cnt = byte_cnt + 32'(n);
      end
      r.kind = 1'b1;
      // Header fields are only reported once the frame got past the marker checks.
      if (st == ST_OK || st == ST_LEN_ERR || st == ST_CRC_ERR) begin
        r.command      = cmd_h;
        r.sequence_res = seq_h;
        r.length       = len_h;
      end
      if (st == ST_OK || st == ST_CRC_ERR) r.rx_crc = crc_h;
      r.status       = st;
      r.good_frames  = good_cnt;
      r.error_frames = err_cnt;
      r.good_bytes   = byte_cnt;
      pending_results.push_back(r);
      clear_frame();
    end else if (emit) begin
      r.payload_byte  = b;
      r.payload_index = 16'(idx - HDR_BYTES);
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 30) $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                seen_count, field, got, want));
  endtask

  task automatic check_result();
    frame_result_t e;
    seen_count++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", seen_count));
      return;
    end
    e = pending_results.pop_front();
    compare_field("kind",          out_tuser,           e.kind);
    compare_field("payload_byte",  out_tdata[7:0],      e.payload_byte);
    compare_field("payload_index", out_tdata[23:8],     e.payload_index);
    compare_field("command",       out_tdata[31:24],    e.command);
    compare_field("sequence",      out_tdata[47:32],    e.sequence_res);
    compare_field("length",        out_tdata[63:48],    e.length);
    compare_field("rx_crc",        out_tdata[79:64],    e.rx_crc);
    compare_field("status",        out_tdata[82:80],    e.status);
    compare_field("good_frames",   out_tdata[114:83],   e.good_frames);
    compare_field("error_frames",  out_tdata[146:115],  e.error_frames);
    compare_field("good_bytes",    out_tdata[178:147],  e.good_bytes);
    compare_field("pad",           out_tdata[183:179],  '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_mk = START_MARKER_RST;
      end_mk   = END_MARKER_RST;
      max_pl   = MAX_PAYLOAD_RST;
      clear_frame();
      good_cnt = '0;
      err_cnt  = '0;
      byte_cnt = '0;
      pending_results.delete();
    end else begin
      // Results leave before new bytes are parsed, so a same-edge input
      // can never be matched against its own expectation.
      if (out_tvalid && out_tready) check_result();
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_START_MARKER: start_mk = cfg_wdata[7:0];
          REG_END_MARKER:   end_mk   = cfg_wdata[7:0];
          REG_MAX_PAYLOAD:  max_pl   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
    end
    pending         <= pending_results.size();
    mismatches      <= fail_count;
    results_checked <= seen_count;
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the framed packet checker testbench: clock, reset, frame stimulus,
// register programming and the final verdict. Depends on fpc_pkg, the block
// and frame_result_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpc_pkg::*;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 3_000_000;
  localparam int         PHASE_BYTES = 300;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_wr_en  = 1'b0;
  logic [1:0]            cfg_index  = '0;
  logic [15:0]           cfg_wdata  = '0;

  int mismatches, pending, results_checked;
  int tx_idle_pct = 14;
  int rx_idle_pct = 88;
  int tx_calm     = 0;
  int rx_calm     = 0;
  int cycle_count = 0;
  int frames_sent = 0;
  int bytes_driven = 0;
  int settings_used = 0;

  logic [7:0]  cur_start = START_MARKER_RST;
  logic [7:0]  cur_end   = END_MARKER_RST;
  logic [15:0] cur_max   = MAX_PAYLOAD_RST;
  logic [7:0]  frame_bytes[$];

  framed_packet_checker uut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_index, .cfg_wdata
  );

  frame_result_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .mismatches, .pending, .results_checked
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure, with occasional stretches of steady ready.
  always @(posedge clk) begin
    if (rx_calm > 0) begin
      rx_calm    <= rx_calm - 1;
      out_tready <= 1'b1;
    end else if ($urandom_range(99) < 2) begin
      rx_calm    <= $urandom_range(40, 10);
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(99) < 2) tx_calm = $urandom_range(40, 10);
    else if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_driven++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // Holds the sender off until every expected result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes all registers plus the unused index; upper data bits are noise
  // for the byte-wide markers.
  task automatic program_regs(input logic [7:0] sm, input logic [7:0] em,
                              input logic [15:0] mp);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_wdata <= {8'($urandom), sm};
    @(posedge clk);
    cfg_index <= REG_END_MARKER;
    cfg_wdata <= {8'($urandom), em};
    @(posedge clk);
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_wdata <= mp;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_start = sm;
    cur_end   = em;
    cur_max   = mp;
    settings_used++;
  endtask

  // A negative fill gives random payload bytes.
  function automatic void build_frame(input logic [7:0] cmd, input logic [15:0] seq,
                                      input int plen, input int fill);
    logic [15:0] crc;
    logic [15:0] len;
    len = 16'(plen);
    frame_bytes = {};
    frame_bytes.push_back(cur_start);
    frame_bytes.push_back(cmd);
    frame_bytes.push_back(seq[15:8]);
    frame_bytes.push_back(seq[7:0]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    repeat (plen) frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    crc = CRC_INIT;
    foreach (frame_bytes[i]) if (i > 0) crc = crc16_byte(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(cur_end);
  endfunction

  // Mostly well-formed frames; the rest carry one defect each or are noise.
  task automatic send_random_frame();
    int plen, pick, at;
    if (cur_max <= 300 && $urandom_range(99) < 8) begin
      plen = int'(cur_max) + int'($urandom_range(2)) - 1;
      if (plen < 0) plen = 0;
    end else begin
      plen = $urandom_range(16);
    end
    build_frame(8'($urandom), 16'($urandom), plen, -1);
    pick = $urandom_range(99);
    if (pick >= 55) begin
      if (pick < 63) begin
        frame_bytes[frame_bytes.size() - 2] ^= 8'($urandom_range(255, 1));
      end else if (pick < 68) begin
        at = $urandom_range(frame_bytes.size() - 4, 1);
        frame_bytes[at] ^= 8'($urandom_range(255, 1));
      end else if (pick < 74) begin
        frame_bytes[0] ^= 8'($urandom_range(255, 1));
      end else if (pick < 80) begin
        frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(255, 1));
      end else if (pick < 86) begin
        // Payload count no longer agrees with the length field.
        if (plen > 0 && $urandom_range(1) == 1) frame_bytes.delete(6);
        else frame_bytes.insert(6, 8'($urandom));
      end else if (pick < 93) begin
        frame_bytes = frame_bytes[0:$urandom_range(frame_bytes.size() - 2)];
      end else begin
        frame_bytes = {};
        repeat ($urandom_range(20, 1)) frame_bytes.push_back(8'($urandom));
      end
    end
    send_frame();
  endtask

  initial begin
    int start_bytes;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed frames under the reset register values.
    build_frame(8'hFF, 16'hFFFF, 0, 0);
    send_frame();
    frame_bytes = {8'h00};
    send_frame();
    build_frame(8'h00, 16'h0000, 0, 0);
    void'(frame_bytes.pop_back());
    send_frame();
    build_frame(8'h00, 16'h0000, 1, 8'hFF);
    send_frame();
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        tx_idle_pct = 88;
        rx_idle_pct = 14;
      end
      if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0:       program_regs(8'h00, 8'hFF, 16'h0000);
        1:       program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(24, 1)));
        2:       program_regs(8'hFF, 8'h00, 16'hFFFF);
        3:       program_regs(START_MARKER_RST, END_MARKER_RST, MAX_PAYLOAD_RST);
        4:       program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(30)));
        default: program_regs(8'($urandom), 8'($urandom), 16'($urandom));
      endcase
      start_bytes = bytes_driven;
      while (bytes_driven - start_bytes < PHASE_BYTES) begin
        send_random_frame();
        if ($urandom_range(99) < 3) drain();
      end
      drain();
    end

    // A longer good frame with the payload limit wide open, then a few
    // random ones under the same setting.
    program_regs(START_MARKER_RST, END_MARKER_RST, 16'hFFFF);
    build_frame(8'h5A, 16'h1234, 40, -1);
    send_frame();
    repeat (2) send_random_frame();
    drain();

    $display("Sent %0d frames (%0d bytes) under %0d register settings.",
             frames_sent, bytes_driven, settings_used);
    $display("Compared %0d results against the prediction.", results_checked);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
